// File: design/hat_pkg.sv
// Shared types and constants for the hash accumulate table.
// Item and result beat layouts, mode and status codes, and the mixer constants.
`default_nettype none

package hat_pkg;

  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int THR_W    = CNT_W + 4;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  localparam logic [3:0] LIMIT_MAX   = 4'd9;
  localparam logic [3:0] LIMIT_RESET = 4'd7;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] weight;
    logic [9:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        occupied;
    logic [63:0] key_out;
    logic [63:0] weight_out;
    logic [10:0] entry_count;
  } result_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [63:0] weight;
  } entry_t;

endpackage

`default_nettype wire

// File: design/hash_accumulate_table_unit.sv
// Add: mixer wait, then a memory probe (lookup and check) per probed slot, then result
// load. Read: a single lookup and check. Clear: one slot per cycle through the sweep.
// One beat in flight at a time; the next beat is taken in the cycle after the result
// loads, later if a stalled result blocks the load.
// Reset (rst, synchronous) clears the used bits with a sweep over all CAPACITY slots,
// holding item_stall high; fill limit resets to seven tenths.
`default_nettype none

module hash_accumulate_table_unit import hat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire item_t      item,
  output logic            result_valid,
  input  wire logic       result_stall,
  output result_t         result,
  input  wire logic       limit_we,
  input  wire logic [3:0] limit_data
);

  logic             accept;
  logic             busy;
  logic             out_free;
  logic             res_load;
  result_t          res;
  logic [THR_W-1:0] threshold;
  logic [3:0]       limit_clamped;

  assign item_stall    = busy;
  assign accept        = item_valid && !busy;
  assign out_free      = !result_valid || !result_stall;
  assign limit_clamped = (limit_data > LIMIT_MAX) ? LIMIT_MAX : limit_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_W'(CAPACITY) * THR_W'(LIMIT_RESET);
    end else if (limit_we) begin
      threshold <= THR_W'(CAPACITY) * THR_W'(limit_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

  hat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .threshold (threshold),
    .out_free  (out_free),
    .busy      (busy),
    .res_load  (res_load),
    .res       (res)
  );

endmodule

`default_nettype wire

// File: design/hat_hash.sv
// Key mixer: 64-bit finalizer built on one shared 32x32 multiplier.
// Each 64-bit product is summed from its low-by-low and two cross partial products in turn. Uses hat_pkg.
`default_nettype none

module hat_hash import hat_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       key,
  output logic                   done,
  output logic [SLOT_W-1:0]      slot
);

  logic        busy;
  logic [2:0]  phase;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] mul_c;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_out;
  logic [63:0] sum;
  logic [63:0] mixed;

  assign mul_c = phase[2] ? MIX_C2 : MIX_C1;
  assign op_a  = (phase[1:0] == 2'd2) ? v[63:32] : v[31:0];
  assign op_b  = (phase[1:0] == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign mul_out = {32'd0, op_a} * {32'd0, op_b};
  assign sum   = acc + {prod[31:0], 32'd0};
  assign mixed = phase[2] ? (sum ^ (sum >> 31)) : (sum ^ (sum >> 27));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= key ^ (key >> 30);
    end else if (busy) begin
      prod <= mul_out;
      unique case (phase[1:0])
        2'd0: begin
        end
        2'd1: begin
          acc <= prod;
        end
        2'd2: begin
          acc <= sum;
        end
        2'd3: begin
          if (phase[2]) begin
            slot <= mixed[SLOT_W-1:0];
          end else begin
            v <= mixed;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/hat_ctrl.sv
// Table sequencer: slot memory, probe loop, insert/accumulate, read and clear sweep.
// Uses hat_pkg and drives the mixer in hat_hash.
`default_nettype none

module hat_ctrl import hat_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire item_t            item,
  input  wire logic [THR_W-1:0] threshold,
  input  wire logic             out_free,
  output logic                  busy,
  output logic                  res_load,
  output result_t               res
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HASH   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_CHECK  = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] sweep_addr;
  logic              sweep_clear;
  logic [CNT_W-1:0]  probe_n;
  logic [CNT_W-1:0]  count;
  logic              op_read;
  logic              in_range;
  logic [63:0]       op_key;
  logic [63:0]       op_weight;
  result_t           res_r;

  entry_t            mem [CAPACITY];
  entry_t            rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              hash_start;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_slot;

  logic              key_hit;
  logic [63:0]       sum;
  logic [THR_W-1:0]  n1;
  logic [THR_W-1:0]  need;
  logic              over;
  logic              do_insert;
  logic              do_acc;
  logic              read_occ;

  hat_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (item.key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign hash_start = accept && (item.mode == MODE_ADD);
  assign busy       = (state != S_IDLE);

  assign key_hit   = (rd_data.key == op_key);
  assign sum       = rd_data.weight + op_weight;
  assign n1        = THR_W'(count) + THR_W'(1);
  assign need      = (n1 << 3) + (n1 << 1);
  assign over      = (need >= threshold);
  assign do_insert = (state == S_CHECK) && !op_read && !rd_data.used && !over;
  assign do_acc    = (state == S_CHECK) && !op_read && rd_data.used && key_hit;
  assign read_occ  = rd_data.used && in_range;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = '{used: 1'b1, key: op_key, weight: (do_acc ? sum : op_weight)};
    if (state == S_SWEEP) begin
      wr_en        = 1'b1;
      wr_addr      = sweep_addr;
      wr_data.used = 1'b0;
    end else if (do_insert || do_acc) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_LOOKUP) begin
      rd_data <= mem[slot];
    end
  end

  always_comb begin
    res             = res_r;
    res.entry_count = 11'(count);
    res_load        = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_clear <= 1'b0;
      count       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_key    <= item.key;
            op_weight <= item.weight;
            op_read   <= (item.mode == MODE_READ);
            in_range  <= ((item.slot_index >> SLOT_W) == '0);
            slot      <= SLOT_W'(item.slot_index);
            probe_n   <= '0;
            if (item.mode[1]) begin
              state       <= S_SWEEP;
              sweep_addr  <= '0;
              sweep_clear <= 1'b1;
              count       <= '0;
            end else if (item.mode == MODE_READ) begin
              state <= S_LOOKUP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot  <= hash_slot;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_DONE;
          if (op_read) begin
            res_r <= '{status: ST_READ, occupied: read_occ,
                       key_out: (read_occ ? rd_data.key : 64'd0),
                       weight_out: (read_occ ? rd_data.weight : 64'd0),
                       entry_count: '0};
          end else if (!rd_data.used) begin
            if (over) begin
              res_r <= '{status: ST_FULL, occupied: 1'b0, key_out: op_key,
                         weight_out: 64'd0, entry_count: '0};
            end else begin
              count <= count + CNT_W'(1);
              res_r <= '{status: ST_INS, occupied: 1'b1, key_out: op_key,
                         weight_out: op_weight, entry_count: '0};
            end
          end else if (key_hit) begin
            res_r <= '{status: ST_ACC, occupied: 1'b1, key_out: op_key,
                       weight_out: sum, entry_count: '0};
          end else if (probe_n == CNT_W'(CAPACITY - 1)) begin
            res_r <= '{status: ST_FULL, occupied: 1'b0, key_out: op_key,
                       weight_out: 64'd0, entry_count: '0};
          end else begin
            slot    <= slot + SLOT_W'(1);
            probe_n <= probe_n + CNT_W'(1);
            state   <= S_LOOKUP;
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + SLOT_W'(1);
          if (sweep_addr == '1) begin
            if (sweep_clear) begin
              res_r <= '{status: ST_CLR, occupied: 1'b0, key_out: 64'd0,
                         weight_out: 64'd0, entry_count: '0};
              state <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted beat left sequencer idle");

  a_hash_owner: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash finished outside hash wait");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not bump count");

endmodule

`default_nettype wire

// File: sim/tb_hash_accumulate_table_unit.sv
// Testbench for hash_accumulate_table_unit: a shadow copy of the probed table
// predicts every result beat, and a scoreboard compares the beats in order.
// Depends on hat_pkg (design/hat_pkg.sv) and the unit itself.
`timescale 1ns / 1ps

module tb_hash_accumulate_table_unit import hat_pkg::*;;

  localparam logic [1:0] MODE_CLEAR     = 2'd2;
  localparam logic [1:0] MODE_CLEAR_ALT = 2'd3;
  localparam int TENTHS      = 10;
  localparam int LAST_SLOT   = CAPACITY - 1;
  localparam int HOLD_AT     = 320;
  localparam int HOLD_CYCLES = 400;

  class shadow_table;
    logic [63:0] key_mem [CAPACITY];
    logic [63:0] weight_mem [CAPACITY];
    bit used [CAPACITY];
    bit ever_set [CAPACITY];
    int written_slots[$];
    int count;
    logic [3:0] limit;
    result_t pending_outcomes[$];
    int errors;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        ever_set[i] = 1'b0;
      end
      count = 0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function logic [SLOT_W-1:0] home_slot(logic [63:0] k);
      logic [63:0] v;
      v = k;
      v = v ^ (v >> 30);
      v = v * MIX_C1;
      v = v ^ (v >> 27);
      v = v * MIX_C2;
      v = v ^ (v >> 31);
      return v[SLOT_W-1:0];
    endfunction

    function void apply_item(item_t it);
      result_t r;
      logic [SLOT_W-1:0] slot;
      bit hit;
      bit open_found;
      int eff;
      r = '0;
      if (it.mode == MODE_READ) begin
        r.status = ST_READ;
        if (used[it.slot_index]) begin
          r.occupied = 1'b1;
          r.key_out = key_mem[it.slot_index];
          r.weight_out = weight_mem[it.slot_index];
        end
      end else if (it.mode == MODE_ADD) begin
        r.key_out = it.key;
        slot = home_slot(it.key);
        hit = 1'b0;
        open_found = 1'b0;
        for (int n = 0; n < CAPACITY && !hit && !open_found; n++) begin
          if (!used[slot]) open_found = 1'b1;
          else if (key_mem[slot] == it.key) hit = 1'b1;
          else slot = slot + 1'b1;
        end
        eff = (limit > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(limit);
        if (hit) begin
          weight_mem[slot] = weight_mem[slot] + it.weight;
          r.status = ST_ACC;
          r.occupied = 1'b1;
          r.weight_out = weight_mem[slot];
        end else if (!open_found || (count + 1) * TENTHS >= CAPACITY * eff) begin
          r.status = ST_FULL;
        end else begin
          key_mem[slot] = it.key;
          weight_mem[slot] = it.weight;
          used[slot] = 1'b1;
          if (!ever_set[slot]) begin
            ever_set[slot] = 1'b1;
            written_slots.push_back(int'(slot));
          end
          count++;
          r.status = ST_INS;
          r.occupied = 1'b1;
          r.weight_out = it.weight;
        end
      end else begin
        // high mode bit set: clear, stored data stays but is hidden
        foreach (used[i]) used[i] = 1'b0;
        count = 0;
        r.status = ST_CLR;
      end
      r.entry_count = count[10:0];
      pending_outcomes.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result beat, status %0d", got.status);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.occupied !== want.occupied) begin
        $error("occupied expected %0d got %0d", want.occupied, got.occupied);
        errors++;
      end
      if (got.key_out !== want.key_out) begin
        $error("key_out expected %h got %h", want.key_out, got.key_out);
        errors++;
      end
      if (got.weight_out !== want.weight_out) begin
        $error("weight_out expected %h got %h", want.weight_out, got.weight_out);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        limit_we = 1'b0;
  logic [3:0]  limit_data = '0;

  shadow_table book;
  logic [63:0] key_pool[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_seen = 0;
  int hold_left = 0;

  hash_accumulate_table_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .limit_we     (limit_we),
    .limit_data   (limit_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        book.match_result(result);
        beats_seen++;
        if (beats_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic item_t pack_item(logic [1:0] mode, logic [63:0] key,
                                      logic [63:0] weight, logic [9:0] slot_index);
    item_t it;
    it.mode = mode;
    it.key = key;
    it.weight = weight;
    it.slot_index = slot_index;
    return it;
  endfunction

  function automatic logic [63:0] key_for_home(logic [9:0] target, logic [63:0] start);
    logic [63:0] k;
    k = start;
    while (book.home_slot(k) != target) k++;
    return k;
  endfunction

  function automatic item_t make_item(int new_pct, int read_pct, int clear_pct);
    item_t it;
    int roll;
    it = pack_item(MODE_ADD, {$urandom, $urandom}, {$urandom, $urandom},
                   10'($urandom_range(LAST_SLOT)));
    roll = $urandom_range(99);
    if (roll < clear_pct) begin
      it.mode = $urandom_range(1) ? MODE_CLEAR : MODE_CLEAR_ALT;
    end else if (roll < clear_pct + read_pct && book.written_slots.size() != 0) begin
      it.mode = MODE_READ;
      it.slot_index = 10'(book.written_slots[$urandom_range(book.written_slots.size() - 1)]);
    end else begin
      if ($urandom_range(99) >= new_pct && key_pool.size() != 0)
        it.key = key_pool[$urandom_range(key_pool.size() - 1)];
      else
        key_pool.push_back(it.key);
      case ($urandom_range(7))
        0: it.weight = '0;
        1: it.weight = '1;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    book.apply_item(it);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] lim, input int items, input int new_pct,
                           input int read_pct, input int clear_pct,
                           input int s_idle, input int r_idle);
    drain_results();
    limit_we <= 1'b1;
    limit_data <= lim;
    @(posedge clk);
    limit_we <= 1'b0;
    book.limit = lim;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (items) send_item(make_item(new_pct, read_pct, clear_pct));
  endtask

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    book = new();
    send_idle_pct = 8;
    recv_idle_pct = 56;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // three keys sharing the last home slot: probe chain wraps to slot 0
    ka = key_for_home(10'(LAST_SLOT), {$urandom, $urandom});
    kb = key_for_home(10'(LAST_SLOT), ka + 1);
    kc = key_for_home(10'(LAST_SLOT), kb + 1);

    send_item(pack_item(MODE_ADD, '0, '0, '0));
    send_item(pack_item(MODE_ADD, '1, '1, '1));
    send_item(pack_item(MODE_ADD, '1, 64'd1, '0));
    send_item(pack_item(MODE_ADD, '0, '1, '1));
    send_item(pack_item(MODE_ADD, '0, '1, '0));
    send_item(pack_item(MODE_ADD, ka, 64'h0123456789abcdef, '1));
    send_item(pack_item(MODE_ADD, kb, {$urandom, $urandom}, '0));
    send_item(pack_item(MODE_ADD, kc, {$urandom, $urandom}, '0));
    send_item(pack_item(MODE_ADD, kb, '1, '0));
    send_item(pack_item(MODE_READ, '1, '1, 10'(LAST_SLOT)));
    send_item(pack_item(MODE_READ, '0, '0, 10'd0));
    send_item(pack_item(MODE_READ, '0, '0, 10'd1));
    send_item(pack_item(MODE_READ, '0, '0, book.home_slot('0)));
    send_item(pack_item(MODE_READ, '0, '0, book.home_slot('1)));
    send_item(pack_item(MODE_CLEAR, '1, '1, '1));
    send_item(pack_item(MODE_READ, '0, '0, 10'd0));
    send_item(pack_item(MODE_ADD, kc, '1, '0));
    send_item(pack_item(MODE_ADD, kc, 64'h8000000000000001, '1));
    send_item(pack_item(MODE_CLEAR_ALT, '0, '0, '0));
    send_item(pack_item(MODE_READ, '0, '0, 10'(LAST_SLOT)));

    run_phase(4'd1, 200, 90, 10, 0, 8, 56);
    run_phase(4'd0, 60, 50, 15, 0, 8, 56);
    run_phase(4'd15, 200, 75, 15, 0, 56, 8);
    run_phase(4'd9, 350, 80, 10, 0, 56, 8);
    run_phase(4'd5, 100, 60, 15, 6, 0, 0);

    drain_results();
    repeat (200) @(posedge clk);
    if (book.errors == 0 && book.pending_outcomes.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
